/* rtl/bpa_pkg.sv */
package bpa_pkg;

  // Default sizing of the page space
  localparam int TOTAL_PAGES_DEF = 4096;
  localparam int ORDER_COUNT_DEF = 11;

  // Free map storage word
  localparam int MAP_W = 32;

  // Field widths
  localparam int OP_W        = 2;
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = 12;
  localparam int FREE_W      = 13;
  localparam int ST_W        = 2;
  localparam int CFG_W       = 13;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // managed_pages after reset
  localparam int CFG_RESET = 4096;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd2;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_SWEEP_START,
    CMD_SWEEP_STEP,
    CMD_ALLOC_START,
    CMD_ALLOC_CHK,
    CMD_SPLIT_WR,
    CMD_FREE_START,
    CMD_FREE_CHK,
    CMD_MERGE_CHK,
    CMD_RESPOND
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t         cmd;
    logic [ST_W-1:0] resp_status;
    logic            resp_grant;
  } dp_ctl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            alloc_bad;
    logic            free_bad;
    logic            last;        // sweep or scan finished on this step
    logic            hit;         // scanned word had a relevant free bit
    logic            split_more;  // another split level follows
    logic            merge_more;  // merge continues one order up
    logic            out_busy;    // result register still held
  } dp_sts_t;

  // Map words holding order o (at least one)
  function automatic int map_words(int total, int o);
    return ((total >> o) + MAP_W - 1) / MAP_W;
  endfunction

  // First map word of order o
  function automatic int map_base(int total, int o);
    int acc;
    acc = 0;
    for (int q = 0; q < o; q++) acc += map_words(total, q);
    return acc;
  endfunction

endpackage

/* rtl/buddy_page_allocator_core.sv */
// Work per item: allocate scans map words, then writes one split level at a time;
//   free checks map words for overlap, then merges buddies one order at a time;
//   reinitialize rewrites every map word (258 at 4096 pages, 11 orders).
// Throughput: one item at a time; the single-port walk over the free map memory sets the rate.
// Reset (rst_n low, synchronous): the map is rebuilt over all map words with in_tready low,
//   then the block idles with every page free.
module buddy_page_allocator_core #(
  parameter int TOTAL_PAGES = bpa_pkg::TOTAL_PAGES_DEF,
  parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] op, [12:2] page_count, [24:13] block_address
  input  logic [bpa_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [13:2] granted_address, [26:14] avail_pages
  output logic [bpa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [bpa_pkg::CFG_W-1:0]           cfg_wr_data
);

  localparam int OUT_USED = bpa_pkg::ST_W + bpa_pkg::ADDR_W + bpa_pkg::FREE_W;

  bpa_pkg::dp_ctl_t ctl;
  bpa_pkg::dp_sts_t sts;

  logic [bpa_pkg::ST_W-1:0]   out_status;
  logic [bpa_pkg::ADDR_W-1:0] out_granted_address;
  logic [bpa_pkg::FREE_W-1:0] out_avail_pages;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bpa_datapath #(
    .TOTAL_PAGES(TOTAL_PAGES),
    .ORDER_COUNT(ORDER_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_op              (in_tdata[1:0]),
    .in_page_count      (in_tdata[12:2]),
    .in_block_address   (in_tdata[24:13]),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .ctl                (ctl),
    .sts                (sts),
    .out_tready         (out_tready),
    .out_valid          (out_tvalid),
    .out_status         (out_status),
    .out_granted_address(out_granted_address),
    .out_avail_pages    (out_avail_pages)
  );

  assign out_tdata = {{(bpa_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                      out_avail_pages, out_granted_address, out_status};

endmodule

/* rtl/bpa_ram.sv */
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 258
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bpa_datapath.sv */
module bpa_datapath #(
  parameter int TOTAL_PAGES = bpa_pkg::TOTAL_PAGES_DEF,
  parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bpa_pkg::OP_W-1:0]    in_op,
  input  logic [bpa_pkg::CNT_W-1:0]   in_page_count,
  input  logic [bpa_pkg::ADDR_W-1:0]  in_block_address,
  input  logic                        cfg_wr_en,
  input  logic [bpa_pkg::CFG_W-1:0]   cfg_wr_data,
  input  bpa_pkg::dp_ctl_t            ctl,
  output bpa_pkg::dp_sts_t            sts,
  input  logic                        out_tready,
  output logic                        out_valid,
  output logic [bpa_pkg::ST_W-1:0]    out_status,
  output logic [bpa_pkg::ADDR_W-1:0]  out_granted_address,
  output logic [bpa_pkg::FREE_W-1:0]  out_avail_pages
);

  localparam int PW      = $clog2(TOTAL_PAGES);
  localparam int NW      = PW + 1;
  localparam int OW      = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int MW      = bpa_pkg::MAP_W;
  localparam int BW      = $clog2(MW);
  localparam int WORDS0  = bpa_pkg::map_words(TOTAL_PAGES, 0);
  localparam int WIW     = (WORDS0 > 1) ? $clog2(WORDS0) : 1;
  localparam int DEPTH   = bpa_pkg::map_base(TOTAL_PAGES, ORDER_COUNT);
  localparam int AW      = $clog2(DEPTH);
  localparam int MAX_BLK = 1 << (ORDER_COUNT - 1);
  localparam int TOP     = ORDER_COUNT - 1;
  localparam int CW      = bpa_pkg::CNT_W;
  localparam int ADW     = bpa_pkg::ADDR_W;
  localparam int FW      = bpa_pkg::FREE_W;
  localparam int LIM_RST = (bpa_pkg::CFG_RESET > TOTAL_PAGES) ? TOTAL_PAGES
                                                              : bpa_pkg::CFG_RESET;

  // Latched request and configuration
  logic [bpa_pkg::OP_W-1:0]  op_r;
  logic [CW-1:0]             n_r;
  logic [ADW-1:0]            addr_r;
  logic [bpa_pkg::CFG_W-1:0] managed_r;

  // Walk state
  logic [NW-1:0]  lim_r, lim_nxt, free_r, free_nxt;
  logic [OW-1:0]  o_r, o_nxt;
  logic [WIW-1:0] w_r, w_nxt;
  logic [BW-1:0]  b_r, b_nxt;
  logic [PW-1:0]  idx_r, idx_nxt, grant_r, grant_nxt;

  // Result register
  logic                      out_valid_r, out_valid_nxt;
  logic [bpa_pkg::ST_W-1:0]  out_status_r, out_status_nxt;
  logic [ADW-1:0]            out_grant_r, out_grant_nxt;
  logic [FW-1:0]             out_free_r, out_free_nxt;

  // Map memory
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  // Per-order constants
  logic [AW-1:0]  base_tab [ORDER_COUNT];
  logic [WIW-1:0] last_tab [ORDER_COUNT];
  logic [NW-1:0]  blk_tab  [ORDER_COUNT];

  // Request decode
  logic [CW-1:0]  nm1;
  logic [OW-1:0]  k_v;
  logic           alloc_bad, free_bad;
  logic [PW-1:0]  pg;
  logic [NW-1:0]  pgn;

  // Word-level helpers
  logic [NW-1:0]  lo_cur, hi_cur, cnt_top, pat_pos, bi;
  logic [WIW-1:0] last_fw, lo_next_w;
  logic           pat_on, at_top, at_last_w, at_k;
  logic [MW-1:0]  pat, fmask;
  logic [BW-1:0]  lb;
  logic           ahit, fhit;
  logic [PW-1:0]  g_new, g_src, sb, mi_new, bud_idx;
  logic           bud_set;

  bpa_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  // Layout tables, folded at elaboration
  always_comb begin
    for (int q = 0; q < ORDER_COUNT; q++) begin
      base_tab[q] = AW'(bpa_pkg::map_base(TOTAL_PAGES, q));
      last_tab[q] = WIW'(bpa_pkg::map_words(TOTAL_PAGES, q) - 1);
      blk_tab[q]  = NW'(TOTAL_PAGES >> q);
    end
  end

  // Size class and request checks
  always_comb begin
    int kk;
    kk  = 0;
    nm1 = n_r - 1'b1;
    for (int b = 0; b < CW; b++) if (nm1[b]) kk = b + 1;
    k_v       = OW'(kk);
    alloc_bad = (n_r == '0) || (int'(n_r) > MAX_BLK);
    free_bad  = (n_r == '0) || ((n_r & nm1) != '0) || (int'(n_r) > MAX_BLK) ||
                ((addr_r & ADW'(nm1)) != '0) ||
                (int'(addr_r) + int'(n_r) > TOTAL_PAGES);
    pg  = PW'(addr_r);
    pgn = NW'(pg) + NW'(n_r);
  end

  // Current word address and per-bit views of it
  always_comb begin
    ram_addr  = base_tab[o_r] + AW'(w_r);
    at_top    = (o_r == OW'(TOP));
    at_last_w = (w_r == last_tab[o_r]);
    at_k      = (o_r == k_v);
    lo_cur    = NW'(pg >> o_r);
    hi_cur    = (o_r >= k_v) ? lo_cur + 1'b1 : (pgn >> o_r);
    last_fw   = WIW'((hi_cur - 1'b1) >> BW);
    lo_next_w = WIW'((pg >> (int'(o_r) + 1)) >> BW);
    cnt_top   = lim_r >> TOP;
    pat_pos   = (lim_r >> (int'(o_r) + 1)) << 1;
    pat_on    = ((lim_r >> o_r) & NW'(1)) != '0;
    lb        = '0;
    for (int b = MW - 1; b >= 0; b--) begin
      bi       = NW'({w_r, BW'(b)});
      pat[b]   = (bi < blk_tab[o_r]) && (at_top ? (bi < cnt_top) : (pat_on && bi == pat_pos));
      fmask[b] = (bi >= lo_cur) && (bi < hi_cur);
      if (ram_rdata[b]) lb = BW'(b);
    end
    ahit    = |ram_rdata;
    fhit    = |(ram_rdata & fmask);
    g_new   = PW'({w_r, lb}) << o_r;
    g_src   = (ctl.cmd == bpa_pkg::CMD_ALLOC_CHK) ? g_new : grant_r;
    sb      = (g_src >> (int'(o_r) - 1)) | PW'(1);
    mi_new  = PW'(pg >> k_v);
    bud_idx = idx_r ^ PW'(1);
    bud_set = (NW'(bud_idx) < blk_tab[o_r]) && ram_rdata[b_r ^ BW'(1)];
  end

  // Command execution
  always_comb begin
    lim_nxt        = lim_r;
    free_nxt       = free_r;
    o_nxt          = o_r;
    w_nxt          = w_r;
    b_nxt          = b_r;
    idx_nxt        = idx_r;
    grant_nxt      = grant_r;
    ram_we         = 1'b0;
    ram_wdata      = ram_rdata;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_free_nxt   = out_free_r;

    sts            = '0;
    sts.op         = op_r;
    sts.alloc_bad  = alloc_bad;
    sts.free_bad   = free_bad;
    sts.out_busy   = out_valid_r && !out_tready;

    unique case (ctl.cmd)
      bpa_pkg::CMD_SWEEP_START: begin
        lim_nxt  = (int'(managed_r) > TOTAL_PAGES) ? NW'(TOTAL_PAGES) : NW'(managed_r);
        free_nxt = lim_nxt;
        o_nxt    = '0;
        w_nxt    = '0;
      end
      bpa_pkg::CMD_SWEEP_STEP: begin
        ram_we    = 1'b1;
        ram_wdata = pat;
        sts.last  = at_top && at_last_w;
        if (at_last_w) begin
          w_nxt = '0;
          if (!at_top) o_nxt = o_r + 1'b1;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      bpa_pkg::CMD_ALLOC_START: begin
        o_nxt = k_v;
        w_nxt = '0;
      end
      bpa_pkg::CMD_ALLOC_CHK: begin
        sts.hit = ahit;
        if (ahit) begin
          // take the lowest free block, then queue the first split
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata & ~(MW'(1) << lb);
          grant_nxt      = g_new;
          free_nxt       = free_r - (NW'(1) << k_v);
          sts.split_more = !at_k;
          if (!at_k) begin
            o_nxt = o_r - 1'b1;
            w_nxt = WIW'(sb >> BW);
            b_nxt = sb[BW-1:0];
          end
        end else begin
          sts.last = at_top && at_last_w;
          if (at_last_w) begin
            w_nxt = '0;
            if (!at_top) o_nxt = o_r + 1'b1;
          end else begin
            w_nxt = w_r + 1'b1;
          end
        end
      end
      bpa_pkg::CMD_SPLIT_WR: begin
        // mark the upper half free at this order
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata | (MW'(1) << b_r);
        sts.split_more = !at_k;
        if (!at_k) begin
          o_nxt = o_r - 1'b1;
          w_nxt = WIW'(sb >> BW);
          b_nxt = sb[BW-1:0];
        end
      end
      bpa_pkg::CMD_FREE_START: begin
        o_nxt = '0;
        w_nxt = WIW'(pg >> BW);
      end
      bpa_pkg::CMD_FREE_CHK: begin
        sts.hit = fhit;
        if (!fhit) begin
          if (w_r == last_fw) begin
            if (at_top) begin
              // no overlap anywhere: start merging at the block's own order
              sts.last = 1'b1;
              o_nxt    = k_v;
              idx_nxt  = mi_new;
              w_nxt    = WIW'(mi_new >> BW);
              b_nxt    = mi_new[BW-1:0];
            end else begin
              o_nxt = o_r + 1'b1;
              w_nxt = lo_next_w;
            end
          end else begin
            w_nxt = w_r + 1'b1;
          end
        end
      end
      bpa_pkg::CMD_MERGE_CHK: begin
        ram_we = 1'b1;
        if (bud_set && !at_top) begin
          // absorb the buddy and move one order up
          sts.merge_more = 1'b1;
          ram_wdata      = ram_rdata & ~(MW'(1) << (b_r ^ BW'(1)));
          idx_nxt        = idx_r >> 1;
          o_nxt          = o_r + 1'b1;
          w_nxt          = WIW'(idx_nxt >> BW);
          b_nxt          = idx_nxt[BW-1:0];
        end else begin
          ram_wdata = ram_rdata | (MW'(1) << b_r);
          free_nxt  = free_r + NW'(n_r);
        end
      end
      bpa_pkg::CMD_RESPOND: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ctl.resp_status;
        out_grant_nxt  = ctl.resp_grant ? ADW'(grant_r) : '0;
        out_free_nxt   = FW'(free_r);
      end
      default: begin
      end
    endcase
  end

  // Control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      managed_r   <= bpa_pkg::CFG_W'(bpa_pkg::CFG_RESET);
      lim_r       <= NW'(LIM_RST);
      free_r      <= NW'(LIM_RST);
      o_r         <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) managed_r <= cfg_wr_data;
      lim_r       <= lim_nxt;
      free_r      <= free_nxt;
      o_r         <= o_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.cmd == bpa_pkg::CMD_LATCH) begin
      op_r   <= in_op;
      n_r    <= in_page_count;
      addr_r <= in_block_address;
    end
    b_r          <= b_nxt;
    idx_r        <= idx_nxt;
    grant_r      <= grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_grant_r;
  assign out_avail_pages     = out_free_r;

endmodule

/* rtl/bpa_ctrl.sv */
module bpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  bpa_pkg::dp_sts_t sts,
  output bpa_pkg::dp_ctl_t ctl
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECODE = 12'b0000_0000_0010,
    S_SWEEP  = 12'b0000_0000_0100,
    S_A_RD   = 12'b0000_0000_1000,
    S_A_CHK  = 12'b0000_0001_0000,
    S_SP_RD  = 12'b0000_0010_0000,
    S_SP_WR  = 12'b0000_0100_0000,
    S_F_RD   = 12'b0000_1000_0000,
    S_F_CHK  = 12'b0001_0000_0000,
    S_M_RD   = 12'b0010_0000_0000,
    S_M_CHK  = 12'b0100_0000_0000,
    S_RESP   = 12'b1000_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     pend_r, pend_nxt;
  logic [bpa_pkg::ST_W-1:0] st_r, st_nxt;
  logic                     gr_r, gr_nxt;

  // Sequencing of one item
  always_comb begin
    state_nxt       = state_r;
    pend_nxt        = pend_r;
    st_nxt          = st_r;
    gr_nxt          = gr_r;
    in_tready       = 1'b0;
    ctl.cmd         = bpa_pkg::CMD_NONE;
    ctl.resp_status = st_r;
    ctl.resp_grant  = gr_r;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.cmd   = bpa_pkg::CMD_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        gr_nxt = 1'b0;
        priority if (sts.op == bpa_pkg::OP_ALLOC && !sts.alloc_bad) begin
          ctl.cmd   = bpa_pkg::CMD_ALLOC_START;
          state_nxt = S_A_RD;
        end else if (sts.op == bpa_pkg::OP_FREE && !sts.free_bad) begin
          ctl.cmd   = bpa_pkg::CMD_FREE_START;
          state_nxt = S_F_RD;
        end else if (sts.op == bpa_pkg::OP_INIT) begin
          ctl.cmd   = bpa_pkg::CMD_SWEEP_START;
          pend_nxt  = 1'b1;
          state_nxt = S_SWEEP;
        end else begin
          st_nxt    = bpa_pkg::ST_BAD;
          state_nxt = S_RESP;
        end
      end
      S_SWEEP: begin
        ctl.cmd = bpa_pkg::CMD_SWEEP_STEP;
        if (sts.last) begin
          pend_nxt  = 1'b0;
          st_nxt    = bpa_pkg::ST_OK;
          state_nxt = pend_r ? S_RESP : S_IDLE;
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        ctl.cmd = bpa_pkg::CMD_ALLOC_CHK;
        if (sts.hit) begin
          st_nxt    = bpa_pkg::ST_OK;
          gr_nxt    = 1'b1;
          state_nxt = sts.split_more ? S_SP_RD : S_RESP;
        end else if (sts.last) begin
          st_nxt    = bpa_pkg::ST_NOSPACE;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_SP_RD: state_nxt = S_SP_WR;
      S_SP_WR: begin
        ctl.cmd   = bpa_pkg::CMD_SPLIT_WR;
        state_nxt = sts.split_more ? S_SP_RD : S_RESP;
      end
      S_F_RD: state_nxt = S_F_CHK;
      S_F_CHK: begin
        ctl.cmd = bpa_pkg::CMD_FREE_CHK;
        priority if (sts.hit) begin
          st_nxt    = bpa_pkg::ST_BAD;
          state_nxt = S_RESP;
        end else if (sts.last) begin
          state_nxt = S_M_RD;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_M_RD: state_nxt = S_M_CHK;
      S_M_CHK: begin
        ctl.cmd = bpa_pkg::CMD_MERGE_CHK;
        if (sts.merge_more) begin
          state_nxt = S_M_RD;
        end else begin
          st_nxt    = bpa_pkg::ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          ctl.cmd   = bpa_pkg::CMD_RESPOND;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Reset enters the map rebuild with no result owed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    gr_r <= gr_nxt;
  end

endmodule

/* rtl/bpa_checker.sv */
module bpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Reset starts the map rebuild: no intake, no result
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ports active right after reset");

  // One item in flight: intake closes after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == bpa_pkg::ST_OK) ||
                   (out_tdata[1:0] == bpa_pkg::ST_NOSPACE) ||
                   (out_tdata[1:0] == bpa_pkg::ST_BAD))
    else $error("undefined status code");

  // A grant address is only shown on success
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != bpa_pkg::ST_OK |-> out_tdata[13:2] == 12'd0)
    else $error("address shown on a failed item");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* tb/tb.sv */
module tb;

  localparam int NPAGES = 4096;
  localparam int NORD = 11;
  localparam int MAXBLK = 1 << (NORD - 1);
  localparam int WD_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  // op code outside the defined set
  localparam logic [bpa_pkg::OP_W-1:0] OP_UNDEF = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bpa_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [bpa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [bpa_pkg::CFG_W-1:0] cfg_wr_data = '0;

  typedef struct packed {
    logic [bpa_pkg::ST_W-1:0] status;
    logic [bpa_pkg::ADDR_W-1:0] grant;
    logic [bpa_pkg::FREE_W-1:0] free_pg;
  } alloc_result_t;

  // predictor state
  bit free_map[NORD][NPAGES];
  int unsigned free_total;
  int unsigned managed;

  alloc_result_t pending_results[$];
  int errors = 0;
  bit quiet_sink = 0;   // when set the receiver never stalls
  bit sink_hold = 0;    // request for a long hold-off on the receiver
  bit quiet_src = 0;
  int idle_cycles = 0;

  // outstanding allocated blocks, used to build legal frees
  int unsigned live_addr[$];
  int unsigned live_size[$];

  buddy_page_allocator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic bit map_at(int o, int unsigned i);
    if (o >= NORD || i >= (NPAGES >> o)) return 0;
    return free_map[o][i];
  endfunction

  function automatic void map_put(int o, int unsigned i, bit v);
    if (o < NORD && i < (NPAGES >> o)) free_map[o][i] = v;
  endfunction

  function automatic void rebuild_map();
    int unsigned left;
    int unsigned pos;
    left = managed;
    pos = 0;
    foreach (free_map[o, i]) free_map[o][i] = 0;
    if (left > NPAGES) left = NPAGES;
    free_total = left;
    for (int o = NORD - 1; o >= 0; o--) begin
      while (left >= (1 << o)) begin
        map_put(o, pos >> o, 1);
        pos += 1 << o;
        left -= 1 << o;
      end
    end
  endfunction

  function automatic logic [bpa_pkg::ST_W-1:0] try_alloc(int unsigned n,
                                                         output int unsigned addr);
    int k;
    int j;
    int idx;
    bit found;
    k = 0;
    idx = 0;
    found = 0;
    addr = 0;
    if (n == 0 || n > MAXBLK) return bpa_pkg::ST_BAD;
    while ((1 << k) < n) k++;
    for (j = k; j < NORD; j++) begin
      for (int i = 0; i < (NPAGES >> j); i++)
        if (free_map[j][i]) begin
          idx = i;
          found = 1;
          break;
        end
      if (found) break;
    end
    if (!found) return bpa_pkg::ST_NOSPACE;
    map_put(j, idx, 0);
    addr = idx << j;
    for (int o = j; o > k; o--) map_put(o - 1, (addr + (1 << (o - 1))) >> (o - 1), 1);
    free_total -= 1 << k;
    return bpa_pkg::ST_OK;
  endfunction

  function automatic logic [bpa_pkg::ST_W-1:0] try_free(int unsigned n, int unsigned addr);
    int k;
    int o;
    int unsigned idx;
    k = 0;
    if (n == 0 || (n & (n - 1)) != 0 || n > MAXBLK) return bpa_pkg::ST_BAD;
    while ((1 << k) < n) k++;
    if ((addr & (n - 1)) != 0 || addr + n > NPAGES) return bpa_pkg::ST_BAD;
    for (o = k; o < NORD; o++) if (map_at(o, addr >> o)) return bpa_pkg::ST_BAD;
    for (o = 0; o < k; o++)
      for (int unsigned i = addr >> o; i < ((addr + n) >> o); i++)
        if (map_at(o, i)) return bpa_pkg::ST_BAD;
    free_total += n;
    idx = addr >> k;
    o = k;
    while (o + 1 < NORD && map_at(o, idx ^ 1)) begin
      map_put(o, idx ^ 1, 0);
      idx >>= 1;
      o++;
    end
    map_put(o, idx, 1);
    return bpa_pkg::ST_OK;
  endfunction

  function automatic alloc_result_t predict_op(logic [1:0] op, int unsigned cnt,
                                               int unsigned addr);
    alloc_result_t r;
    int unsigned g;
    g = 0;
    r = '0;
    if (op == bpa_pkg::OP_ALLOC) begin
      r.status = try_alloc(cnt, g);
      if (r.status != bpa_pkg::ST_OK) g = 0;
      else begin
        live_addr.push_back(g);
        live_size.push_back(1 << $clog2(cnt));
      end
    end else if (op == bpa_pkg::OP_FREE) begin
      r.status = try_free(cnt, addr);
    end else if (op == bpa_pkg::OP_INIT) begin
      rebuild_map();
      live_addr.delete();
      live_size.delete();
      r.status = bpa_pkg::ST_OK;
    end else begin
      r.status = bpa_pkg::ST_BAD;
    end
    r.grant = g[bpa_pkg::ADDR_W-1:0];
    r.free_pg = free_total[bpa_pkg::FREE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one item, with random gaps before it
  task automatic send_item(logic [1:0] op, int unsigned cnt, int unsigned addr);
    int unsigned cnt_f;
    int unsigned addr_f;
    cnt_f = cnt & 32'h7FF;
    addr_f = addr & 32'hFFF;
    @(negedge clk);
    if (!quiet_src && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 19)) @(negedge clk);
    pending_results.push_back(predict_op(op, cnt_f, addr_f));
    in_tdata <= {7'd0, addr_f[bpa_pkg::ADDR_W-1:0], cnt_f[bpa_pkg::CNT_W-1:0], op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_managed(int unsigned v);
    wait_drained();
    cfg_wr_data <= v[bpa_pkg::CFG_W-1:0];
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    managed = v & 13'h1FFF;
  endtask

  task automatic free_random_live();
    int p;
    int unsigned a;
    int unsigned s;
    p = $urandom_range(0, live_addr.size() - 1);
    a = live_addr[p];
    s = live_size[p];
    live_addr.delete(p);
    live_size.delete(p);
    send_item(bpa_pkg::OP_FREE, s, a);
  endtask

  // receiver: random stall bursts, or a long hold-off counted here
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold = 0;
      end else if (!quiet_sink && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      alloc_result_t got;
      alloc_result_t want;
      got.status = out_tdata[1:0];
      got.grant = out_tdata[13:2];
      got.free_pg = out_tdata[26:14];
      if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.grant != want.grant) report_mismatch("granted_address", got.grant, want.grant);
        if (got.free_pg != want.free_pg)
          report_mismatch("avail_pages", got.free_pg, want.free_pg);
      end
    end
  end

  // watchdog on accept activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_special_cases();
    send_item(bpa_pkg::OP_ALLOC, 0, 0);
    send_item(bpa_pkg::OP_ALLOC, MAXBLK + 1, 0);
    send_item(bpa_pkg::OP_ALLOC, 11'h7FF, 12'hFFF);
    send_item(OP_UNDEF, 11'h7FF, 12'hFFF);
    send_item(bpa_pkg::OP_FREE, 0, 0);
    send_item(bpa_pkg::OP_FREE, 3, 0);
    send_item(bpa_pkg::OP_FREE, 4, 2);
    send_item(bpa_pkg::OP_FREE, 1, 0);
    send_item(bpa_pkg::OP_ALLOC, 1, 0);
    send_item(bpa_pkg::OP_ALLOC, 3, 0);
    send_item(bpa_pkg::OP_ALLOC, MAXBLK, 0);
    send_item(bpa_pkg::OP_FREE, 1, 0);
    send_item(bpa_pkg::OP_FREE, 1, 0);
    send_item(bpa_pkg::OP_FREE, 4, 4);
    send_item(bpa_pkg::OP_FREE, MAXBLK, 12'hC00);
    send_item(bpa_pkg::OP_FREE, 1, 12'hFFF);
    // exhaust the space
    for (int i = 0; i < 5; i++) send_item(bpa_pkg::OP_ALLOC, MAXBLK, 0);
    send_item(bpa_pkg::OP_INIT, 0, 0);
  endtask

  task automatic test_init_settings();
    int unsigned vals[6] = '{0, 1, 4095, 8191, 1027, 4096};
    foreach (vals[i]) begin
      write_managed(vals[i]);
      send_item(bpa_pkg::OP_INIT, $urandom, $urandom);
      send_item(bpa_pkg::OP_ALLOC, 1, 0);
      send_item(bpa_pkg::OP_ALLOC, 2, 0);
      // freeing the last page, which lies past the managed range when fewer pages are managed
      send_item(bpa_pkg::OP_FREE, 1, 12'hFFF);
    end
  endtask

  task automatic test_backpressure();
    sink_hold = 1;
    for (int i = 0; i < 8; i++) send_item(bpa_pkg::OP_ALLOC, $urandom_range(1, 8), 0);
    wait_drained();
  endtask

  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
        send_item(bpa_pkg::OP_ALLOC, (1 << $urandom_range(0, 5)) + $urandom_range(0, 3), 0);
      else if (r < 48) send_item(bpa_pkg::OP_ALLOC, $urandom_range(1, MAXBLK), $urandom);
      else if (r < 85 && live_addr.size() != 0) free_random_live();
      else if (r < 95) send_item(bpa_pkg::OP_FREE, $urandom, $urandom);
      else if (r < 97) send_item(bpa_pkg::OP_INIT, $urandom, $urandom);
      else send_item($urandom_range(0, 3), $urandom, $urandom);
    end
  endtask

  task automatic test_random();
    random_phase(350);
    write_managed($urandom_range(1, 4096));
    send_item(bpa_pkg::OP_INIT, 0, 0);
    random_phase(350);
    write_managed(4096);
    send_item(bpa_pkg::OP_INIT, 0, 0);
    random_phase(200);
    // final stretch without idling
    quiet_src = 1;
    quiet_sink = 1;
    random_phase(150);
  endtask

  initial begin
    managed = bpa_pkg::CFG_RESET;
    rebuild_map();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_init_settings();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
